// ===== src/rk4rl_pkg.sv =====
// Shared types, constants and saturating helpers for the RK4 R-L load step unit.
package rk4rl_pkg;

  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned FRAC_BITS  = 24;
  localparam int unsigned CHANNELS   = 4;
  localparam int unsigned CH_WIDTH   = $clog2(CHANNELS);
  localparam int unsigned TIME_WIDTH = 48;
  localparam int unsigned REG_WIDTH  = 31;
  localparam int unsigned NUM_REGS   = 5;
  localparam int unsigned IDX_WIDTH  = 3;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic [REG_WIDTH-1:0]         reg_t;
  typedef logic [TIME_WIDTH-1:0]        time_t;
  typedef logic [IDX_WIDTH-1:0]         reg_idx_t;

  // configuration register indexes
  localparam reg_idx_t REG_STEP_SIZE = 3'd0;
  localparam reg_idx_t REG_RES_1     = 3'd1;
  localparam reg_idx_t REG_INV_IND_1 = 3'd2;
  localparam reg_idx_t REG_RES_3     = 3'd3;
  localparam reg_idx_t REG_INV_IND_3 = 3'd4;

  localparam reg_t STEP_SIZE_RST = reg_t'(1678);
  localparam reg_t UNITY_RST     = reg_t'(64'd1 << FRAC_BITS);

  localparam data_t ONE_SIXTH = data_t'(((64'd1 << FRAC_BITS) + 64'd3) / 64'd6);
  localparam data_t ONE_THIRD = data_t'(((64'd1 << FRAC_BITS) + 64'd1) / 64'd3);

  localparam data_t VAL_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam data_t VAL_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  typedef struct packed {
    reg_t step_size;
    reg_t resistance_1;
    reg_t inv_inductance_1;
    reg_t resistance_3;
    reg_t inv_inductance_3;
  } cfg_t;

  typedef struct packed {
    data_t voltage_x1;
    data_t voltage_y1;
    data_t voltage_x3;
    data_t voltage_y3;
  } in_item_t;

  typedef struct packed {
    data_t current_x1;
    data_t current_y1;
    data_t current_x3;
    data_t current_y3;
    time_t elapsed_time;
  } out_item_t;

  function automatic data_t sat_add(input data_t a, input data_t b);
    logic signed [DATA_WIDTH:0] sum;
    sum = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
    if (sum[DATA_WIDTH] != sum[DATA_WIDTH-1]) begin
      return sum[DATA_WIDTH] ? VAL_MIN : VAL_MAX;
    end
    return sum[DATA_WIDTH-1:0];
  endfunction

  function automatic data_t sat_sub(input data_t a, input data_t b);
    logic signed [DATA_WIDTH:0] dif;
    dif = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
    if (dif[DATA_WIDTH] != dif[DATA_WIDTH-1]) begin
      return dif[DATA_WIDTH] ? VAL_MIN : VAL_MAX;
    end
    return dif[DATA_WIDTH-1:0];
  endfunction

endpackage

// ===== src/rk4rl_stream_if.sv =====
// Valid/ready stream channel carrying one payload beat.
interface rk4rl_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/rk4_rl_load_step_unit.sv =====
// RK4 R-L load step unit: one beat in holds four load voltages; the unit advances the four
// branch currents di/dt = (u - i*R)/L by one fourth-order Runge-Kutta step of size h and
// returns the new currents with the elapsed time (time += h, wrapping at 48 bits). All
// arithmetic is signed Q8.24 with floor-scaled products and saturating sums. A single
// 32x32 multiplier does all the work: each channel needs 14 multiplications, each done as
// a multiply step followed by a scale, saturate and update step, and a finishing state
// then waits until the output register is drained. The input is not ready while an item
// is in flight, so a new input beat is taken only once the last item is finished; a
// finished result waits in the output register while the next item is accepted and
// computed.
module rk4_rl_load_step_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  rk4rl_pkg::reg_idx_t      cfg_idx_i,
  input  rk4rl_pkg::reg_t          cfg_data_i,
  rk4rl_stream_if.sink             in_i,
  rk4rl_stream_if.source           out_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  localparam logic [2:0] STAGE_K1  = 3'd0;
  localparam logic [2:0] STAGE_K2  = 3'd1;
  localparam logic [2:0] STAGE_K3  = 3'd2;
  localparam logic [2:0] STAGE_K4  = 3'd3;
  localparam logic [2:0] STAGE_SUM = 3'd4;

  localparam logic [1:0] SUB_RES = 2'd0;  // i*R, or the k1+k4 term in the sum stage
  localparam logic [1:0] SUB_IND = 2'd1;  // times 1/L, or the k2+k3 term
  localparam logic [1:0] SUB_STEP = 2'd2; // times h

  localparam logic [rk4rl_pkg::CH_WIDTH-1:0] LAST_CH =
    rk4rl_pkg::CH_WIDTH'(rk4rl_pkg::CHANNELS - 1);
  localparam logic [rk4rl_pkg::CH_WIDTH-1:0] CH_ONE = rk4rl_pkg::CH_WIDTH'(1);

  rk4rl_pkg::cfg_t  cfg;
  rk4rl_pkg::data_t mul_a;
  rk4rl_pkg::data_t mul_b;
  rk4rl_pkg::data_t mul_res;
  logic             mul_en;

  logic [1:0]                    state_q;
  logic [rk4rl_pkg::CH_WIDTH-1:0] ch_q;
  logic [2:0]                    stage_q;
  logic [1:0]                    sub_q;
  logic                          wb_q;
  logic                          out_valid_q;
  rk4rl_pkg::time_t              time_q;
  rk4rl_pkg::data_t              cur_q [rk4rl_pkg::CHANNELS];

  rk4rl_pkg::data_t volt_q [rk4rl_pkg::CHANNELS];
  rk4rl_pkg::data_t k_q    [4];
  rk4rl_pkg::data_t x_q;
  rk4rl_pkg::data_t w_q;
  rk4rl_pkg::data_t i0_q;
  rk4rl_pkg::data_t u_q;
  rk4rl_pkg::out_item_t out_q;

  logic                          accept;
  logic                          run_wb;
  logic                          ch_done;
  logic                          fin_load;
  logic [rk4rl_pkg::CH_WIDTH-1:0] load_idx;
  rk4rl_pkg::data_t              load_cur;
  rk4rl_pkg::data_t              load_u;
  rk4rl_pkg::data_t              new_cur;
  rk4rl_pkg::data_t              r_sel;
  rk4rl_pkg::data_t              il_sel;
  rk4rl_pkg::data_t              h_val;

  rk4rl_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  rk4rl_mulq u_mulq (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .res_o (mul_res)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign run_wb     = (state_q == S_RUN) && wb_q;
  assign mul_en     = (state_q == S_RUN) && !wb_q;
  assign ch_done    = run_wb && (stage_q == STAGE_SUM) && (sub_q == SUB_IND);
  assign fin_load   = (state_q == S_FIN) && (!out_valid_q || out_o.ready);

  assign h_val  = rk4rl_pkg::data_t'({1'b0, cfg.step_size});
  // bit 1 of the channel picks the third harmonic branch
  assign r_sel  = ch_q[1] ? rk4rl_pkg::data_t'({1'b0, cfg.resistance_3})
                          : rk4rl_pkg::data_t'({1'b0, cfg.resistance_1});
  assign il_sel = ch_q[1] ? rk4rl_pkg::data_t'({1'b0, cfg.inv_inductance_3})
                          : rk4rl_pkg::data_t'({1'b0, cfg.inv_inductance_1});

  // next channel to load: channel zero on accept, otherwise the one after ch_q
  assign load_idx = (state_q == S_IDLE) ? '0 : ch_q + CH_ONE;
  assign load_cur = cur_q[load_idx];
  assign load_u   = (state_q == S_IDLE) ? in_i.data.voltage_x1 : volt_q[load_idx];
  assign new_cur  = rk4rl_pkg::sat_add(rk4rl_pkg::sat_add(x_q, mul_res), i0_q);

  always_comb begin
    mul_a = x_q;
    mul_b = r_sel;
    if (stage_q == STAGE_SUM) begin
      mul_a = w_q;
      mul_b = (sub_q == SUB_RES) ? rk4rl_pkg::ONE_SIXTH : rk4rl_pkg::ONE_THIRD;
    end else begin
      case (sub_q)
        SUB_RES: begin
          mul_a = x_q;
          mul_b = r_sel;
        end
        SUB_IND: begin
          mul_a = w_q;
          mul_b = il_sel;
        end
        SUB_STEP: begin
          mul_a = h_val;
          mul_b = w_q;
        end
        default: begin
          mul_a = x_q;
          mul_b = r_sel;
        end
      endcase
    end
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ch_q        <= '0;
      stage_q     <= STAGE_K1;
      sub_q       <= SUB_RES;
      wb_q        <= 1'b0;
      out_valid_q <= 1'b0;
      time_q      <= '0;
      for (int c = 0; c < rk4rl_pkg::CHANNELS; c++) begin
        cur_q[c] <= '0;
      end
    end else begin
      if (out_valid_q && out_o.ready && !fin_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_RUN;
            ch_q    <= '0;
            stage_q <= STAGE_K1;
            sub_q   <= SUB_RES;
            wb_q    <= 1'b0;
          end
        end
        S_RUN: begin
          wb_q <= !wb_q;
          if (wb_q) begin
            if (stage_q == STAGE_SUM) begin
              if (sub_q == SUB_RES) begin
                sub_q <= SUB_IND;
              end else begin
                cur_q[ch_q] <= new_cur;
                stage_q     <= STAGE_K1;
                sub_q       <= SUB_RES;
                if (ch_q == LAST_CH) begin
                  state_q <= S_FIN;
                end else begin
                  ch_q <= ch_q + CH_ONE;
                end
              end
            end else if (sub_q == SUB_STEP) begin
              sub_q   <= SUB_RES;
              stage_q <= stage_q + 3'd1;
            end else begin
              sub_q <= sub_q + 2'd1;
            end
          end
        end
        S_FIN: begin
          // hold until the output register is free
          if (fin_load) begin
            out_valid_q <= 1'b1;
            time_q      <= time_q + rk4rl_pkg::TIME_WIDTH'(cfg.step_size);
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath working registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      volt_q[0] <= in_i.data.voltage_x1;
      volt_q[1] <= in_i.data.voltage_y1;
      volt_q[2] <= in_i.data.voltage_x3;
      volt_q[3] <= in_i.data.voltage_y3;
    end
    if (accept || (ch_done && ch_q != LAST_CH)) begin
      x_q  <= load_cur;
      i0_q <= load_cur;
      u_q  <= load_u;
    end else if (run_wb) begin
      if (stage_q == STAGE_SUM) begin
        if (sub_q == SUB_RES) begin
          x_q <= mul_res;
          w_q <= rk4rl_pkg::sat_add(k_q[1], k_q[2]);
        end
      end else begin
        case (sub_q)
          SUB_RES:  w_q <= rk4rl_pkg::sat_sub(u_q, mul_res);
          SUB_IND:  w_q <= mul_res;
          SUB_STEP: begin
            k_q[stage_q[1:0]] <= mul_res;
            case (stage_q)
              STAGE_K1, STAGE_K2: x_q <= rk4rl_pkg::sat_add(i0_q, mul_res >>> 1);
              STAGE_K3:           x_q <= rk4rl_pkg::sat_add(i0_q, mul_res);
              STAGE_K4:           w_q <= rk4rl_pkg::sat_add(k_q[0], mul_res);
              default: ;
            endcase
          end
          default: ;
        endcase
      end
    end
    if (fin_load) begin
      out_q.current_x1   <= cur_q[0];
      out_q.current_y1   <= cur_q[1];
      out_q.current_x3   <= cur_q[2];
      out_q.current_y3   <= cur_q[3];
      out_q.elapsed_time <= time_q + rk4rl_pkg::TIME_WIDTH'(cfg.step_size);
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

// ===== src/rk4rl_cfg.sv =====
// Configuration register file: step size, resistances and reciprocal inductances.
module rk4rl_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                we_i,
  input  rk4rl_pkg::reg_idx_t idx_i,
  input  rk4rl_pkg::reg_t     data_i,
  output rk4rl_pkg::cfg_t     cfg_o
);

  rk4rl_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_size        <= rk4rl_pkg::STEP_SIZE_RST;
      cfg_q.resistance_1     <= rk4rl_pkg::UNITY_RST;
      cfg_q.inv_inductance_1 <= rk4rl_pkg::UNITY_RST;
      cfg_q.resistance_3     <= rk4rl_pkg::UNITY_RST;
      cfg_q.inv_inductance_3 <= rk4rl_pkg::UNITY_RST;
    end else if (we_i) begin
      // drop writes beyond the last register
      case (idx_i)
        rk4rl_pkg::REG_STEP_SIZE: cfg_q.step_size        <= data_i;
        rk4rl_pkg::REG_RES_1:     cfg_q.resistance_1     <= data_i;
        rk4rl_pkg::REG_INV_IND_1: cfg_q.inv_inductance_1 <= data_i;
        rk4rl_pkg::REG_RES_3:     cfg_q.resistance_3     <= data_i;
        rk4rl_pkg::REG_INV_IND_3: cfg_q.inv_inductance_3 <= data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/rk4rl_mulq.sv =====
// Shared fixed-point multiplier: registered product, floor scale and saturation.
module rk4rl_mulq (
  input  logic                clk_i,
  input  logic                en_i,
  input  rk4rl_pkg::data_t    a_i,
  input  rk4rl_pkg::data_t    b_i,
  output rk4rl_pkg::data_t    res_o
);

  localparam int unsigned PW = 2 * rk4rl_pkg::DATA_WIDTH;
  localparam int unsigned DW = rk4rl_pkg::DATA_WIDTH;

  logic signed [PW-1:0] prod_q;
  logic signed [PW-1:0] scaled;
  logic [PW-DW:0]       upper;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= PW'(a_i) * PW'(b_i);
    end
  end

  // arithmetic shift floors toward minus infinity
  assign scaled = prod_q >>> rk4rl_pkg::FRAC_BITS;
  assign upper  = scaled[PW-1:DW-1];

  always_comb begin
    if ((&upper) || !(|upper)) begin
      res_o = scaled[DW-1:0];
    end else begin
      res_o = prod_q[PW-1] ? rk4rl_pkg::VAL_MIN : rk4rl_pkg::VAL_MAX;
    end
  end

endmodule
